### hdl/cocs_pkg.sv
package cocs_pkg;

    localparam int C_MAX_LEN       = 64;
    localparam int C_RANK_ENTRIES  = 256;
    localparam int C_QUEUE_DEPTH   = 2;
    localparam int C_QUEUE_AW      = $clog2(C_QUEUE_DEPTH);
    localparam int C_QUEUE_CW      = $clog2(C_QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_RANK,
        OP_TEXT,
        OP_RUN
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
    } t_qent;

    typedef struct packed {
        logic       ins;
        logic       shift;
        logic [7:0] ch;
        logic [7:0] rank;
    } t_row_ctl;

endpackage

### hdl/cocs_if.sv
interface cocs_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] char_value;
    logic       last;

    modport source (output valid, output req_type, output char_value, output last,
                    input ready);
    modport sink   (input valid, input req_type, input char_value, input last,
                    output ready);
endinterface

interface cocs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] sorted_char;
    logic       last_out;
    logic       overflowed;

    modport source (output valid, output sorted_char, output last_out, output overflowed,
                    input ready);
    modport sink   (input valid, input sorted_char, input last_out, input overflowed,
                    output ready);
endinterface

### hdl/custom_order_char_sort.sv
// custom order character sort
// i_in carries one byte per beat: req_type low gives an order byte, which sets the
// rank of its character to its place in the order string (a later repeat wins);
// req_type high gives a text byte, buffered up to MAX_LEN, with extra bytes dropped.
// a text byte with last high closes the run: the buffer comes out on o_out sorted
// stably by ascending rank, one character per beat, last_out on the final one and
// overflowed on every beat if any byte was dropped. ranks and counters clear when
// the sort pass ends. bytes are taken at one per cycle, while the queue has room,
// into a two-entry queue in front of the engine. after the closing byte leaves the
// queue the sort pass reads the buffer, then the rank table, and inserts each byte
// into the sorted row; results leave at one beat per cycle while o_out is ready.
// while results are stalled the queue keeps taking input until it holds two beats.
// reset empties the queue and the row and sets every rank to zero; no clearing
// pass is needed.
module custom_order_char_sort import cocs_pkg::*; #(
    parameter int MAX_LEN = C_MAX_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cocs_in_if.sink     i_in,
    cocs_out_if.source  o_out
);

    t_qent w_q;
    logic  w_q_vld;
    logic  w_q_pop;

    cocs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_q     (w_q),
        .o_q_vld (w_q_vld),
        .i_q_pop (w_q_pop)
    );

    cocs_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_q),
        .i_q_vld (w_q_vld),
        .o_q_pop (w_q_pop),
        .o_out   (o_out)
    );

endmodule

### hdl/cocs_front.sv
module cocs_front import cocs_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cocs_in_if.sink        i_in,
    output t_qent          o_q,
    output logic           o_q_vld,
    input  logic           i_q_pop
);

    t_qent                  r_q [C_QUEUE_DEPTH];
    logic [C_QUEUE_AW-1:0]  r_wr_ptr;
    logic [C_QUEUE_AW-1:0]  r_rd_ptr;
    logic [C_QUEUE_CW-1:0]  r_cnt;
    logic [C_QUEUE_CW-1:0]  n_cnt;
    t_qent                  w_ent;
    logic                   w_push;
    logic                   w_pop;

    // classify the incoming beat
    always_comb begin
        w_ent.ch = i_in.char_value;
        if (!i_in.req_type) begin
            w_ent.op = OP_RANK;
        end else if (i_in.last) begin
            w_ent.op = OP_RUN;
        end else begin
            w_ent.op = OP_TEXT;
        end
    end

    assign i_in.ready = (r_cnt != C_QUEUE_CW'(C_QUEUE_DEPTH));
    assign w_push     = i_in.valid && i_in.ready;
    assign o_q_vld    = (r_cnt != '0);
    assign w_pop      = i_q_pop && o_q_vld;
    assign o_q        = r_q[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + C_QUEUE_CW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - C_QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + C_QUEUE_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + C_QUEUE_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_ent;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= C_QUEUE_CW'(C_QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + C_QUEUE_CW'(1)))
        else $error("queue count missed a push");
    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_cnt == $past(r_cnt) - C_QUEUE_CW'(1)))
        else $error("queue count missed a pop");
`endif

endmodule

### hdl/cocs_ins_row.sv
module cocs_ins_row import cocs_pkg::*; #(
    parameter int  MAX_LEN = C_MAX_LEN,
    localparam int CW      = $clog2(MAX_LEN + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_row_ctl       i_ctl,
    output logic [7:0]     o_head_char,
    output logic [CW-1:0]  o_fill
);

    logic [7:0]         r_ch [MAX_LEN];
    logic [7:0]         r_rk [MAX_LEN];
    logic [CW-1:0]      r_fill;
    logic [MAX_LEN-1:0] w_gt;
    logic [MAX_LEN-1:0] w_dn_gt;
    logic [7:0]         w_up_ch [MAX_LEN];
    logic [7:0]         w_up_rk [MAX_LEN];
    logic [7:0]         w_dn_ch [MAX_LEN];
    logic [7:0]         w_dn_rk [MAX_LEN];

    // empty cells count as larger than any rank, so the new entry lands after equals
    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        assign w_gt[i] = (CW'(i) >= r_fill) || (r_rk[i] > i_ctl.rank);

        if (i == MAX_LEN - 1) begin : g_top
            assign w_up_ch[i] = r_ch[i];
            assign w_up_rk[i] = r_rk[i];
        end else begin : g_mid
            assign w_up_ch[i] = r_ch[i+1];
            assign w_up_rk[i] = r_rk[i+1];
        end

        if (i == 0) begin : g_first
            assign w_dn_gt[i] = 1'b0;
            assign w_dn_ch[i] = i_ctl.ch;
            assign w_dn_rk[i] = i_ctl.rank;
        end else begin : g_rest
            assign w_dn_gt[i] = w_gt[i-1];
            assign w_dn_ch[i] = r_ch[i-1];
            assign w_dn_rk[i] = r_rk[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.shift) begin
                r_ch[i] <= w_up_ch[i];
                r_rk[i] <= w_up_rk[i];
            end else if (i_ctl.ins && w_gt[i]) begin
                if (w_dn_gt[i]) begin
                    r_ch[i] <= w_dn_ch[i];
                    r_rk[i] <= w_dn_rk[i];
                end else begin
                    r_ch[i] <= i_ctl.ch;
                    r_rk[i] <= i_ctl.rank;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ctl.shift) begin
            r_fill <= r_fill - CW'(1);
        end else if (i_ctl.ins) begin
            r_fill <= r_fill + CW'(1);
        end
    end

    assign o_head_char = r_ch[0];
    assign o_fill      = r_fill;

endmodule

### hdl/cocs_back.sv
module cocs_back import cocs_pkg::*; #(
    parameter int MAX_LEN = C_MAX_LEN
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_qent          i_q,
    input  logic           i_q_vld,
    output logic           o_q_pop,
    cocs_out_if.source     o_out
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    t_state                    r_state;
    t_state                    n_state;
    logic [7:0]                r_rank_mem [C_RANK_ENTRIES];
    logic [C_RANK_ENTRIES-1:0] r_rvld;
    logic [7:0]                r_buf [MAX_LEN];
    logic [7:0]                r_opos;
    logic [CW-1:0]             r_tcnt;
    logic                      r_drop;
    logic                      r_emit_ovf;
    logic [CW-1:0]             r_rd_idx;
    logic                      r_s1_vld;
    logic [7:0]                r_s1_ch;
    logic                      r_s2_vld;
    logic [7:0]                r_s2_ch;
    logic [7:0]                r_s2_rank;
    logic                      r_s2_hit;
    logic                      w_is_rank;
    logic                      w_is_text;
    logic                      w_rank_wr;
    logic                      w_buf_wr;
    logic                      w_room;
    logic                      w_issue;
    logic                      w_sort_done;
    logic                      w_emit;
    t_row_ctl                  w_row_ctl;
    logic [7:0]                w_head;
    logic [CW-1:0]             w_fill;

    assign w_is_rank = (i_q.op == OP_RANK);
    assign w_is_text = (i_q.op inside {OP_TEXT, OP_RUN});
    assign w_room    = (r_tcnt < CW'(MAX_LEN));
    assign w_rank_wr = o_q_pop && w_is_rank;
    assign w_buf_wr  = o_q_pop && w_is_text && w_room;
    assign w_issue   = (r_state == ST_SORT) && (r_rd_idx < r_tcnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        w_sort_done = 1'b0;
        w_emit      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_vld) begin
                    o_q_pop = 1'b1;
                    if (i_q.op == OP_RUN) begin
                        n_state = ST_SORT;
                    end
                end
            end
            ST_SORT: begin
                if (!w_issue && !r_s1_vld && !r_s2_vld) begin
                    w_sort_done = 1'b1;
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                w_emit = 1'b1;
                if (o_out.ready && (w_fill == CW'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld     <= '0;
            r_opos     <= '0;
            r_tcnt     <= '0;
            r_drop     <= 1'b0;
            r_emit_ovf <= 1'b0;
            r_rd_idx   <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
        end else begin
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
            if (w_issue) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            if (w_rank_wr) begin
                r_rvld[i_q.ch] <= 1'b1;
                r_opos         <= r_opos + 8'd1;
            end
            if (o_q_pop && w_is_text) begin
                if (w_room) begin
                    r_tcnt <= r_tcnt + CW'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (o_q_pop && (i_q.op == OP_RUN)) begin
                r_rd_idx <= '0;
            end
            // ranks and counters clear once the run sits sorted in the row
            if (w_sort_done) begin
                r_rvld     <= '0;
                r_opos     <= '0;
                r_tcnt     <= '0;
                r_drop     <= 1'b0;
                r_emit_ovf <= r_drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rank_wr) begin
            r_rank_mem[i_q.ch] <= r_opos;
        end
        r_s2_rank <= r_rank_mem[r_s1_ch];
    end

    always_ff @(posedge i_clk) begin
        if (w_buf_wr) begin
            r_buf[r_tcnt[AW-1:0]] <= i_q.ch;
        end
        r_s1_ch <= r_buf[r_rd_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_s2_ch  <= r_s1_ch;
        r_s2_hit <= r_rvld[r_s1_ch];
    end

    always_comb begin
        w_row_ctl.ins   = r_s2_vld;
        w_row_ctl.shift = w_emit && o_out.ready;
        w_row_ctl.ch    = r_s2_ch;
        w_row_ctl.rank  = r_s2_hit ? r_s2_rank : 8'd0;
    end

    cocs_ins_row #(
        .MAX_LEN (MAX_LEN)
    ) u_row (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_row_ctl),
        .o_head_char (w_head),
        .o_fill      (w_fill)
    );

    assign o_out.valid       = w_emit;
    assign o_out.sorted_char = w_head;
    assign o_out.last_out    = (w_fill == CW'(1));
    assign o_out.overflowed  = r_emit_ovf;

`ifndef SYNTHESIS
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (w_fill != '0))
        else $error("result beat offered from an empty row");
    a_clear_after_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sort_done |=> ((r_rvld == '0) && (r_tcnt == '0) && (r_opos == '0) && !r_drop))
        else $error("rank table or counters not cleared after sort");
    a_tcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcnt <= CW'(MAX_LEN))
        else $error("text count beyond buffer length");
    a_beat_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready) |=> (w_fill == $past(w_fill) - CW'(1)))
        else $error("row fill did not drop on a result beat");
`endif

endmodule

### tb/custom_order_char_sort_test.sv
`timescale 1ns / 1ps

module custom_order_char_sort_test;
    import cocs_pkg::*;

    localparam bit ORDER_BYTE  = 1'b0;
    localparam bit TEXT_BYTE   = 1'b1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_value;
        logic       last;
    } t_byte_beat;

    typedef struct packed {
        logic [7:0] sorted_char;
        logic       last_out;
        logic       overflowed;
    } t_sorted_beat;

    typedef struct {
        t_byte_beat beat;
        int         gap;
    } t_queued_beat;

    logic i_clk;
    logic i_rst_n;

    cocs_in_if  in_bus ();
    cocs_out_if out_bus ();

    custom_order_char_sort u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // predictor state
    logic [7:0]   char_rank [256];
    logic [7:0]   order_pos;
    logic [7:0]   held_text [$];
    logic         text_dropped;

    t_queued_beat pending_q [$];
    t_sorted_beat sorted_due [$];
    t_sorted_beat want;
    t_queued_beat next_up;

    logic in_taken;
    int   out_beats;
    int   fails;
    int   cycles;
    int   sent;
    int   hold_left;
    int   calm_left;
    int   stall_pick;
    bit   long_hold_done;
    bit   overflow_done;

    function automatic void clear_model();
        foreach (char_rank[c]) char_rank[c] = 8'd0;
        order_pos    = 8'd0;
        held_text.delete();
        text_dropped = 1'b0;
    endfunction

    function automatic void absorb_byte(t_byte_beat b);
        logic [7:0]   run [$];
        logic [7:0]   key;
        int           j;
        t_sorted_beat res;
        if (b.req_type == ORDER_BYTE) begin
            char_rank[b.char_value] = order_pos;
            order_pos = order_pos + 8'd1;
            return;
        end
        if (held_text.size() < C_MAX_LEN) begin
            held_text.insert(held_text.size(), b.char_value);
        end else begin
            text_dropped = 1'b1;
        end
        if (!b.last) return;
        run = held_text;
        // stable insertion by ascending rank
        for (int i = 1; i < run.size(); i++) begin
            key = run[i];
            j = i;
            while (j > 0 && char_rank[run[j-1]] > char_rank[key]) begin
                run[j] = run[j-1];
                j--;
            end
            run[j] = key;
        end
        foreach (run[k]) begin
            res.sorted_char = run[k];
            res.last_out    = (k == run.size() - 1);
            res.overflowed  = text_dropped;
            sorted_due.insert(sorted_due.size(), res);
        end
        clear_model();
    endfunction

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_char(logic [7:0] base);
        if ($urandom_range(0, 9) < 8) return base + 8'($urandom_range(0, 15));
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic push_beat(bit req_type, logic [7:0] ch, bit last, bit burst);
        t_queued_beat q;
        q.beat = '{req_type, ch, last};
        q.gap  = burst ? 0 : pause_len();
        pending_q.insert(pending_q.size(), q);
        sent++;
    endtask

    task automatic add_run(int order_len, int text_len, bit burst);
        logic [7:0] base;
        bit         fin;
        base = 8'($urandom_range(1, 240));
        for (int k = 0; k < order_len; k++) begin
            fin = (k == order_len - 1) ? bit'($urandom_range(0, 1))
                                       : ($urandom_range(0, 15) == 0);
            push_beat(ORDER_BYTE, pick_char(base), fin, burst);
        end
        for (int k = 0; k < text_len; k++) begin
            // order bytes may land in the middle of the text
            if ($urandom_range(0, 9) == 0) push_beat(ORDER_BYTE, pick_char(base), 1'b0, burst);
            push_beat(TEXT_BYTE, pick_char(base), k == text_len - 1, burst);
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || in_bus.valid || sorted_due.size() > 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("Some tests failed");
            $finish;
        end
    end

    // input beats into the predictor
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_bus.valid && in_bus.ready;
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            absorb_byte('{in_bus.req_type, in_bus.char_value, in_bus.last});
        end
    end

    // byte driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_bus.valid || in_taken)) begin
            if (pending_q.size() == 0) begin
                in_bus.valid <= 1'b0;
            end else if (pending_q[0].gap > 0) begin
                in_bus.valid <= 1'b0;
                pending_q[0].gap = pending_q[0].gap - 1;
            end else begin
                next_up = pending_q.pop_front();
                in_bus.req_type   <= next_up.beat.req_type;
                in_bus.char_value <= next_up.beat.char_value;
                in_bus.last       <= next_up.beat.last;
                in_bus.valid      <= 1'b1;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (!long_hold_done && out_beats >= 40) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            out_bus.ready  <= 1'b0;
        end else if (hold_left > 0) begin
            out_bus.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (calm_left > 0) begin
            out_bus.ready <= 1'b1;
            calm_left     <= calm_left - 1;
        end else if ($urandom_range(0, 99) == 0) begin
            out_bus.ready <= 1'b1;
            calm_left     <= $urandom_range(100, 300);
        end else begin
            stall_pick = pause_len();
            if (stall_pick > 0) begin
                out_bus.ready <= 1'b0;
                hold_left     <= stall_pick - 1;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            out_beats++;
            if (sorted_due.size() == 0) begin
                $display("%0t: beat with nothing expected, expected none, got char %02h",
                         $time, out_bus.sorted_char);
                fails++;
            end else begin
                want = sorted_due.pop_front();
                if (out_bus.sorted_char !== want.sorted_char) begin
                    $display("%0t: sorted_char expected %02h got %02h",
                             $time, want.sorted_char, out_bus.sorted_char);
                    fails++;
                end
                if (out_bus.last_out !== want.last_out) begin
                    $display("%0t: last_out expected %0b got %0b",
                             $time, want.last_out, out_bus.last_out);
                    fails++;
                end
                if (out_bus.overflowed !== want.overflowed) begin
                    $display("%0t: overflowed expected %0b got %0b",
                             $time, want.overflowed, out_bus.overflowed);
                    fails++;
                end
            end
        end
    end

    initial begin
        in_bus.valid      = 1'b0;
        in_bus.req_type   = ORDER_BYTE;
        in_bus.char_value = 8'd0;
        in_bus.last       = 1'b0;
        out_bus.ready     = 1'b0;
        i_rst_n           = 1'b0;
        clear_model();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ranks from order string, repeated ranks kept stable
        push_beat(ORDER_BYTE, "c", 1'b0, 1'b0);
        push_beat(ORDER_BYTE, "b", 1'b0, 1'b0);
        push_beat(ORDER_BYTE, "a", 1'b1, 1'b0);
        push_beat(TEXT_BYTE, "a", 1'b0, 1'b0);
        push_beat(TEXT_BYTE, "b", 1'b0, 1'b0);
        push_beat(TEXT_BYTE, "c", 1'b0, 1'b0);
        push_beat(TEXT_BYTE, "a", 1'b0, 1'b0);
        push_beat(TEXT_BYTE, "b", 1'b1, 1'b0);
        // order string goes on past its last flag; extreme values; unranked char
        push_beat(ORDER_BYTE, 8'hFF, 1'b1, 1'b0);
        push_beat(ORDER_BYTE, 8'h01, 1'b0, 1'b0);
        push_beat(TEXT_BYTE, 8'h01, 1'b0, 1'b0);
        push_beat(TEXT_BYTE, 8'h80, 1'b0, 1'b0);
        push_beat(TEXT_BYTE, 8'hFF, 1'b1, 1'b0);
        // later duplicate wins, order bytes between text bytes
        push_beat(ORDER_BYTE, "x", 1'b0, 1'b0);
        push_beat(ORDER_BYTE, "y", 1'b0, 1'b0);
        push_beat(ORDER_BYTE, "x", 1'b0, 1'b0);
        push_beat(TEXT_BYTE, "x", 1'b0, 1'b0);
        push_beat(TEXT_BYTE, "y", 1'b0, 1'b0);
        push_beat(ORDER_BYTE, "y", 1'b0, 1'b0);
        push_beat(TEXT_BYTE, "z", 1'b1, 1'b0);
        // single byte run with no order string
        push_beat(TEXT_BYTE, "q", 1'b1, 1'b0);
        wait_drained();

        sent = 0;
        // order string longer than the rank range wraps
        add_run(260, 8, 1'b1);
        while (sent < 370) begin
            if (!overflow_done && sent > 200) begin
                // last byte arrives on a full buffer
                add_run(3, 65, 1'b0);
                overflow_done = 1'b1;
            end else begin
                add_run($urandom_range(0, 12),
                        ($urandom_range(0, 11) == 0) ? $urandom_range(30, 64)
                                                     : $urandom_range(1, 16),
                        $urandom_range(0, 4) == 0);
            end
        end
        wait_drained();
        repeat (3 * C_MAX_LEN + 20) @(posedge i_clk);

        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
